// ===== src/go_back_n_sender_window_unit_assert.svh =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit_assert.svh
// Assertion macros for the Go-Back-N sender window unit.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH

// prop holds at every clock edge outside reset
`define GBN_ASSERT_HOLDS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cond at one edge implies prop at the next edge
`define GBN_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants and types of the Go-Back-N sender window unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_BITS     = 3;
  localparam int PAYLOAD_BITS = 32;

  localparam int SLOT_BITS = $clog2(WINDOW);
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  localparam int CMP_BITS  = (SEQ_BITS > CNT_BITS) ? SEQ_BITS : CNT_BITS;

  // operation codes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // timer commands
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef struct packed {
    logic                    packet_valid;
    logic [SEQ_BITS-1:0]     packet_seq;
    logic [PAYLOAD_BITS-1:0] packet_data;
    logic                    accepted;
    logic [1:0]              timer_cmd;
    logic                    window_full;
    logic                    last;
  } gbn_res_t;

endpackage

// ===== src/go_back_n_sender_window_unit.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-Back-N ARQ sender window: window of 4, 3-bit sequence numbers.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o  | op, payload, ack_number,
//           |           |                          | ack_check_ok
//   out     | output    | out_valid_o / out_stall_i| packet_valid, packet_seq,
//           |           |                          | packet_data, accepted,
//           |           |                          | timer_cmd, window_full, last
//
// Sequence: a send or a bad-checksum ack runs the count and output steps,
//   a good ack the count, ack and output steps, a timeout the count step
//   then a read and an emit step per outstanding packet (output when none).
//   Steps use the shared modulo adder at most once; buffer reads are registered.
// Reset: asynchronous, active low; window empty, base and next at zero.
// Stalls: results pass through one output register; while it holds a
//   stalled result, the sequencer waits to hand over its next result.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit
  import gbn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              op_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [SEQ_BITS-1:0]     ack_number_i,
  input  logic                    ack_check_ok_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    packet_valid_o,
  output logic [SEQ_BITS-1:0]     packet_seq_o,
  output logic [PAYLOAD_BITS-1:0] packet_data_o,
  output logic                    accepted_o,
  output logic [1:0]              timer_cmd_o,
  output logic                    window_full_o,
  output logic                    last_o
);

  logic     res_valid;
  logic     res_ready;
  gbn_res_t res;

  logic     out_valid_q, out_valid_d;
  gbn_res_t out_q, out_d;

  gbn_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .payload_i     (payload_i),
    .ack_number_i  (ack_number_i),
    .ack_check_ok_i(ack_check_ok_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign packet_valid_o = out_q.packet_valid;
  assign packet_seq_o   = out_q.packet_seq;
  assign packet_data_o  = out_q.packet_data;
  assign accepted_o     = out_q.accepted;
  assign timer_cmd_o    = out_q.timer_cmd;
  assign window_full_o  = out_q.window_full;
  assign last_o         = out_q.last;

  `include "go_back_n_sender_window_unit_assert.svh"

  // an accepted input makes the sequencer busy in the next cycle
  `GBN_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept not followed by busy")

  // only a retransmission run produces more than one result per transaction
  `GBN_ASSERT_HOLDS(a_multi_only_rtx, !(out_valid_o && !last_o) || (packet_valid_o && !accepted_o), "non-final result outside a retransmission run")

  // a timer start goes only with an accepted send
  `GBN_ASSERT_HOLDS(a_start_on_send, !(out_valid_o && timer_cmd_o == TMR_START) || (accepted_o && packet_valid_o), "timer start without accepted send")

endmodule

// ===== src/gbn_alu.sv =====
// ----------------------------------------------------------------------------
// gbn_alu
// Shared modulo sequence-number adder/subtractor.
// ----------------------------------------------------------------------------
module gbn_alu
  import gbn_pkg::*;
(
  input  logic [SEQ_BITS-1:0] a_i,
  input  logic [SEQ_BITS-1:0] b_i,
  input  logic                sub_i,
  output logic [SEQ_BITS-1:0] res_o
);

  // wraps modulo 2^SEQ_BITS
  assign res_o = sub_i ? (a_i - b_i) : (a_i + b_i);

endmodule

// ===== src/gbn_store.sv =====
// ----------------------------------------------------------------------------
// gbn_store
// Packet buffer, one slot per window position, registered read.
// ----------------------------------------------------------------------------
module gbn_store
  import gbn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [SLOT_BITS-1:0]    wr_addr_i,
  input  logic [PAYLOAD_BITS-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [SLOT_BITS-1:0]    rd_addr_i,
  output logic [PAYLOAD_BITS-1:0] rd_data_o
);

  logic [PAYLOAD_BITS-1:0] mem_q [WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: window state, ack check and retransmission run over the
// shared adder and the packet buffer.
// ----------------------------------------------------------------------------
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              op_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [SEQ_BITS-1:0]     ack_number_i,
  input  logic                    ack_check_ok_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output gbn_res_t                res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COUNT = 3'd1;
  localparam logic [2:0] ST_ACK   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [1:0]              op_q, op_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic [SEQ_BITS-1:0]     ack_q, ack_d;
  logic                    ok_q, ok_d;
  logic [SEQ_BITS-1:0]     base_q, base_d;
  logic [SEQ_BITS-1:0]     next_q, next_d;
  logic                    full_q, full_d;
  logic [CNT_BITS-1:0]     n_q, n_d;
  logic [SLOT_BITS-1:0]    idx_q, idx_d;
  logic [SEQ_BITS-1:0]     seq_q, seq_d;
  gbn_res_t                res_q, res_d;

  logic [SEQ_BITS-1:0]     alu_a, alu_b, alu_res;
  logic                    alu_sub;
  logic                    wr_en, rd_en;
  logic [SLOT_BITS-1:0]    wr_addr, rd_addr;
  logic [PAYLOAD_BITS-1:0] rd_data;

  logic [SEQ_BITS-1:0]     next_inc, ack_inc, wnd_end;
  logic [CNT_BITS-1:0]     n_now, idx_cnt;
  logic                    run_last, in_win;

  gbn_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .res_o(alu_res)
  );

  gbn_store u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(payload_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign next_inc = next_q + SEQ_BITS'(1);
  assign ack_inc  = ack_q + SEQ_BITS'(1);
  assign wnd_end  = base_q + SEQ_BITS'(WINDOW);
  assign idx_cnt  = CNT_BITS'(idx_q) + CNT_BITS'(1);
  assign run_last = (idx_cnt == n_q);
  assign wr_addr  = SLOT_BITS'(next_q % SEQ_BITS'(WINDOW));
  assign rd_addr  = SLOT_BITS'(alu_res % SEQ_BITS'(WINDOW));

  // outstanding count, valid while alu computes next - base
  assign n_now = full_q ? CNT_BITS'(WINDOW) :
                 ((CMP_BITS'(alu_res) > CMP_BITS'(WINDOW)) ? CNT_BITS'(WINDOW)
                                                            : CNT_BITS'(alu_res));
  // valid while alu computes ack - base
  assign in_win = CMP_BITS'(alu_res) < CMP_BITS'(n_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    payload_d   = payload_q;
    ack_d       = ack_q;
    ok_d        = ok_q;
    base_d      = base_q;
    next_d      = next_q;
    full_d      = full_q;
    n_d         = n_q;
    idx_d       = idx_q;
    seq_d       = seq_q;
    res_d       = res_q;
    alu_a       = next_q;
    alu_b       = base_q;
    alu_sub     = 1'b1;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    res_valid_o = 1'b0;
    res_o       = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_i;
          payload_d = payload_i;
          ack_d     = ack_number_i;
          ok_d      = ack_check_ok_i;
          state_d   = ST_COUNT;
        end
      end

      ST_COUNT: begin
        n_d               = n_now;
        res_d             = '0;
        res_d.window_full = full_q;
        res_d.last        = 1'b1;
        state_d           = ST_OUT;
        unique case (op_q)
          OP_SEND: begin
            if (!full_q) begin
              wr_en              = 1'b1;
              next_d             = next_inc;
              full_d             = (next_inc == wnd_end);
              res_d.packet_valid = 1'b1;
              res_d.packet_seq   = next_q;
              res_d.packet_data  = payload_q;
              res_d.accepted     = 1'b1;
              res_d.timer_cmd    = (n_now == '0) ? TMR_START : TMR_NONE;
              res_d.window_full  = (next_inc == wnd_end);
            end
          end
          OP_ACK: begin
            if (ok_q) begin
              state_d = ST_ACK;
            end
          end
          OP_TIMEOUT: begin
            if (n_now == '0) begin
              res_d.timer_cmd = TMR_RESTART;
            end else begin
              idx_d   = '0;
              state_d = ST_RD;
            end
          end
          default: begin
          end
        endcase
      end

      ST_ACK: begin
        alu_a             = ack_q;
        res_d             = '0;
        res_d.last        = 1'b1;
        res_d.window_full = full_q;
        if (in_win) begin
          base_d            = ack_inc;
          full_d            = 1'b0;
          res_d.window_full = 1'b0;
          res_d.timer_cmd   = (next_q == ack_inc) ? TMR_STOP : TMR_RESTART;
        end else begin
          res_d.timer_cmd   = (n_q == '0) ? TMR_STOP : TMR_RESTART;
        end
        state_d = ST_OUT;
      end

      ST_RD: begin
        alu_a   = base_q;
        alu_b   = SEQ_BITS'(idx_q);
        alu_sub = 1'b0;
        rd_en   = 1'b1;
        seq_d   = alu_res;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        res_valid_o        = 1'b1;
        res_o.packet_valid = 1'b1;
        res_o.packet_seq   = seq_q;
        res_o.packet_data  = rd_data;
        res_o.accepted     = 1'b0;
        res_o.timer_cmd    = (idx_q == '0) ? TMR_RESTART : TMR_NONE;
        res_o.window_full  = full_q;
        res_o.last         = run_last;
        if (res_ready_i) begin
          if (run_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + SLOT_BITS'(1);
            state_d = ST_RD;
          end
        end
      end

      ST_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q  <= '0;
      next_q  <= '0;
      full_q  <= 1'b0;
      n_q     <= '0;
      idx_q   <= '0;
      op_q    <= OP_SEND;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      next_q  <= next_d;
      full_q  <= full_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      op_q    <= op_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    ack_q     <= ack_d;
    seq_q     <= seq_d;
    res_q     <= res_d;
  end

endmodule
